// ===== sv/rlse_pkg.sv =====
// shared types and constants for the rv32i alu / load / store execute unit
// no dependencies; imported by rv32i_alu_load_store_execute_unit
package rlse_pkg;

    localparam int MEM_BYTES_DEF = 4096;

    localparam int XLEN   = 32;
    localparam int REG_AW = 5;
    localparam int NREGS  = 32;
    localparam int CMD_W  = 5;

    // s side tdata: dest, src1, src2, immediate, pc packed from bit 0, padded to bytes
    localparam int S_TDATA_W = 80;
    // m side tdata: written_reg, written_value, padded to bytes
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 5'd0,
        CMD_SUB   = 5'd1,
        CMD_XOR   = 5'd2,
        CMD_OR    = 5'd3,
        CMD_AND   = 5'd4,
        CMD_SLL   = 5'd5,
        CMD_SRL   = 5'd6,
        CMD_SRA   = 5'd7,
        CMD_SLT   = 5'd8,
        CMD_SLTU  = 5'd9,
        CMD_LUI   = 5'd10,
        CMD_AUIPC = 5'd11,
        CMD_ADDI  = 5'd12,
        CMD_XORI  = 5'd13,
        CMD_ORI   = 5'd14,
        CMD_ANDI  = 5'd15,
        CMD_SLLI  = 5'd16,
        CMD_SRLI  = 5'd17,
        CMD_SRAI  = 5'd18,
        CMD_SLTI  = 5'd19,
        CMD_SLTIU = 5'd20,
        CMD_LB    = 5'd21,
        CMD_LH    = 5'd22,
        CMD_LW    = 5'd23,
        CMD_LBU   = 5'd24,
        CMD_LHU   = 5'd25,
        CMD_SB    = 5'd26,
        CMD_SH    = 5'd27,
        CMD_SW    = 5'd28
    } t_cmd;

endpackage

// ===== sv/rv32i_alu_load_store_execute_unit.sv =====
// rv32i integer execute unit: alu ops, lui/auipc, loads and stores
// depends on rlse_pkg and rlse_ram (register file copies, four byte lanes of data memory)
//
//  channel  dir  tdata                                        tuser
//  s        in   dest[4:0] src1[9:5] src2[14:10]              command[4:0]
//                imm[46:15] pc[78:47]
//  m        out  written_reg[4:0] written_value[36:5]         reg_written[0]
//                                                             unknown_command[1]
//
// one instruction per cycle while the m side is not stalled; a result passes through register file read
// on the transfer edge, execute / memory access and the output register before it is offered.
// after reset a clearing pass zeroes data memory, one row of four bytes a cycle, with s_tready
// low throughout. MEM_BYTES must be a power of two.
// a stall on the m side holds the whole pipeline; operands are forwarded from
// writeback so no hazard stalls are needed.
module rv32i_alu_load_store_execute_unit #(
    parameter int MEM_BYTES = rlse_pkg::MEM_BYTES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [rlse_pkg::S_TDATA_W-1:0] i_s_tdata,   // dest, src1, src2, immediate, pc
    input  logic [rlse_pkg::CMD_W-1:0]     i_s_tuser,   // command
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [rlse_pkg::M_TDATA_W-1:0] o_m_tdata,   // written_reg, written_value
    output logic [rlse_pkg::M_TUSER_W-1:0] o_m_tuser    // reg_written, unknown_command
);

    import rlse_pkg::*;

    localparam int MEM_AW   = $clog2(MEM_BYTES);
    localparam int ROWS     = MEM_BYTES / 4;
    localparam int ROW_AW   = MEM_AW - 2;
    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

    // input field unpacking
    logic [REG_AW-1:0] in_rd, in_rs1, in_rs2;
    assign in_rd  = i_s_tdata[4:0];
    assign in_rs1 = i_s_tdata[9:5];
    assign in_rs2 = i_s_tdata[14:10];

    // control
    logic adv;
    logic accept;
    logic r_clr_active;
    logic [ROW_AW-1:0] r_clr_row;

    // stage 1: operands being read from the register file
    logic              r_s1_valid;
    logic [CMD_W-1:0]  r_s1_cmd;
    logic [REG_AW-1:0] r_s1_rd, r_s1_rs1, r_s1_rs2;
    logic [XLEN-1:0]   r_s1_imm, r_s1_pc;

    // stage 2: result or load data pending
    logic              r_s2_valid;
    logic              r_s2_wr;
    logic              r_s2_unk;
    logic              r_s2_load;
    t_cmd              r_s2_cmd;
    logic [1:0]        r_s2_lane0;
    logic [REG_AW-1:0] r_s2_rd;
    logic [XLEN-1:0]   r_s2_val;
    logic [XLEN-1:0]   s2_val;

    // last register write, covers a read in the same edge as that write
    logic              r_lw_valid;
    logic [REG_AW-1:0] r_lw_rd;
    logic [XLEN-1:0]   r_lw_val;

    logic [NREGS-1:0]  r_rf_valid;
    logic [XLEN-1:0]   rf_rdata1, rf_rdata2;
    logic              rf_we;

    // output register
    logic              r_out_valid;
    logic              r_out_wr;
    logic              r_out_unk;
    logic [REG_AW-1:0] r_out_rd;
    logic [XLEN-1:0]   r_out_val;

    // data memory lanes
    logic [ROW_AW-1:0] mem_row   [4];
    logic [3:0]        mem_we;
    logic [7:0]        mem_wdata [4];
    logic [7:0]        mem_rdata [4];

    // execute
    logic [XLEN-1:0] op_a, op_b, opnd2, addr, n_s2_val;
    logic            is_load, is_store, writes, unk;
    logic [2:0]      st_bytes;
    logic [4:0]      shamt;

    assign adv        = !r_out_valid || i_m_tready;
    assign o_s_tready = adv && !r_clr_active;
    assign accept     = i_s_tvalid && o_s_tready;
    assign rf_we      = adv && r_s2_valid && r_s2_wr;

    rlse_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2_rd),
        .i_wdata (s2_val),
        .i_re    (adv),
        .i_raddr (in_rs1),
        .o_rdata (rf_rdata1)
    );

    rlse_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_s2_rd),
        .i_wdata (s2_val),
        .i_re    (adv),
        .i_raddr (in_rs2),
        .o_rdata (rf_rdata2)
    );

    // operand forwarding: stage 2 result, then last write, then register file
    always_comb begin
        op_a = r_rf_valid[r_s1_rs1] ? rf_rdata1 : '0;
        if (r_lw_valid && r_lw_rd == r_s1_rs1) begin
            op_a = r_lw_val;
        end
        if (r_s2_valid && r_s2_wr && r_s2_rd == r_s1_rs1) begin
            op_a = s2_val;
        end
        if (r_s1_rs1 == '0) begin
            op_a = '0;
        end

        op_b = r_rf_valid[r_s1_rs2] ? rf_rdata2 : '0;
        if (r_lw_valid && r_lw_rd == r_s1_rs2) begin
            op_b = r_lw_val;
        end
        if (r_s2_valid && r_s2_wr && r_s2_rd == r_s1_rs2) begin
            op_b = s2_val;
        end
        if (r_s1_rs2 == '0) begin
            op_b = '0;
        end
    end

    always_comb begin
        opnd2    = (r_s1_cmd < CMD_LUI) ? op_b : r_s1_imm;
        shamt    = opnd2[4:0];
        addr     = op_a + r_s1_imm;
        n_s2_val = '0;
        is_load  = 1'b0;
        is_store = 1'b0;
        writes   = 1'b1;
        unk      = 1'b0;
        st_bytes = 3'd0;
        case (t_cmd'(r_s1_cmd))
            CMD_ADD, CMD_ADDI:   n_s2_val = op_a + opnd2;
            CMD_SUB:             n_s2_val = op_a - opnd2;
            CMD_XOR, CMD_XORI:   n_s2_val = op_a ^ opnd2;
            CMD_OR, CMD_ORI:     n_s2_val = op_a | opnd2;
            CMD_AND, CMD_ANDI:   n_s2_val = op_a & opnd2;
            CMD_SLL, CMD_SLLI:   n_s2_val = op_a << shamt;
            CMD_SRL, CMD_SRLI:   n_s2_val = op_a >> shamt;
            CMD_SRA, CMD_SRAI:   n_s2_val = XLEN'($signed(op_a) >>> shamt);
            CMD_SLT, CMD_SLTI:   n_s2_val = {31'd0, $signed(op_a) < $signed(opnd2)};
            CMD_SLTU, CMD_SLTIU: n_s2_val = {31'd0, op_a < opnd2};
            CMD_LUI:             n_s2_val = {r_s1_imm[19:0], 12'd0};
            CMD_AUIPC:           n_s2_val = {r_s1_imm[19:0], 12'd0} + r_s1_pc;
            CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: is_load = 1'b1;
            CMD_SB: begin
                is_store = 1'b1;
                writes   = 1'b0;
                st_bytes = 3'd1;
            end
            CMD_SH: begin
                is_store = 1'b1;
                writes   = 1'b0;
                st_bytes = 3'd2;
            end
            CMD_SW: begin
                is_store = 1'b1;
                writes   = 1'b0;
                st_bytes = 3'd4;
            end
            default: begin
                unk    = 1'b1;
                writes = 1'b0;
            end
        endcase
    end

    // lane l holds byte k = l - addr[1:0] of the access; lanes below the start use the next row
    always_comb begin
        logic [1:0] k;
        for (int l = 0; l < 4; l++) begin
            k = 2'(l) - addr[1:0];
            if (r_clr_active) begin
                mem_row[l]   = r_clr_row;
                mem_we[l]    = 1'b1;
                mem_wdata[l] = '0;
            end else begin
                mem_row[l]   = (2'(l) >= addr[1:0]) ? addr[MEM_AW-1:2]
                                                    : addr[MEM_AW-1:2] + 1'b1;
                mem_we[l]    = adv && r_s1_valid && is_store && ({1'b0, k} < st_bytes);
                mem_wdata[l] = op_b[8*k +: 8];
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        rlse_ram #(.WIDTH(8), .DEPTH(ROWS)) u_lane (
            .i_clk   (i_clk),
            .i_we    (mem_we[g]),
            .i_waddr (mem_row[g]),
            .i_wdata (mem_wdata[g]),
            .i_re    (adv),
            .i_raddr (mem_row[g]),
            .o_rdata (mem_rdata[g])
        );
    end

    // load data assembly in stage 2
    always_comb begin
        logic [7:0] lb [4];
        for (int k = 0; k < 4; k++) begin
            lb[k] = mem_rdata[r_s2_lane0 + 2'(k)];
        end
        s2_val = r_s2_val;
        if (r_s2_load) begin
            case (r_s2_cmd)
                CMD_LB:  s2_val = {{24{lb[0][7]}}, lb[0]};
                CMD_LH:  s2_val = {{16{lb[1][7]}}, lb[1], lb[0]};
                CMD_LBU: s2_val = {24'd0, lb[0]};
                CMD_LHU: s2_val = {16'd0, lb[1], lb[0]};
                default: s2_val = {lb[3], lb[2], lb[1], lb[0]};
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_row    <= '0;
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_lw_valid   <= 1'b0;
            r_rf_valid   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_row <= r_clr_row + 1'b1;
                if (r_clr_row == ROW_LAST) begin
                    r_clr_active <= 1'b0;
                end
            end
            if (adv) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= r_s2_valid;
            end
            if (rf_we) begin
                r_rf_valid[r_s2_rd] <= 1'b1;
                r_lw_valid          <= 1'b1;
            end
        end

        if (accept) begin
            r_s1_cmd <= i_s_tuser;
            r_s1_rd  <= in_rd;
            r_s1_rs1 <= in_rs1;
            r_s1_rs2 <= in_rs2;
            r_s1_imm <= i_s_tdata[46:15];
            r_s1_pc  <= i_s_tdata[78:47];
        end
        if (adv && r_s1_valid) begin
            r_s2_wr    <= writes && (r_s1_rd != '0);
            r_s2_unk   <= unk;
            r_s2_load  <= is_load;
            r_s2_cmd   <= t_cmd'(r_s1_cmd);
            r_s2_lane0 <= addr[1:0];
            r_s2_rd    <= r_s1_rd;
            r_s2_val   <= n_s2_val;
        end
        if (rf_we) begin
            r_lw_rd  <= r_s2_rd;
            r_lw_val <= s2_val;
        end
        if (adv && r_s2_valid) begin
            r_out_wr  <= r_s2_wr;
            r_out_unk <= r_s2_unk;
            r_out_rd  <= r_s2_wr ? r_s2_rd : '0;
            r_out_val <= r_s2_wr ? s2_val : '0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'd0, r_out_val, r_out_rd};
    assign o_m_tuser  = {r_out_unk, r_out_wr};

    a_no_transfer_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_active |-> !o_s_tready)
        else $error("input transfer possible during memory clear");

    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_s2_rd != '0))
        else $error("register file write to x0");

    a_unknown_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (!o_m_tuser[0] && o_m_tdata == '0))
        else $error("unknown command result carries a register write");

    a_s2_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !adv) |=> (r_s2_valid && $stable(r_s2_val) && $stable(r_s2_rd)))
        else $error("stage 2 changed during output stall");

    a_no_mem_write_and_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && is_load) |-> (mem_we == '0))
        else $error("data memory written by a load");

endmodule

// ===== sv/rlse_ram.sv =====
// generic single-write, single-read synchronous ram with registered read data
// no dependencies; used for the register file copies and the data memory lanes
module rlse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
